/* hdl/assert_macros.svh */
// assertion macros used by the deframer rtl (sfd_deframer)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sfd_pkg.sv */
// shared types and constants of the sweep frame deframer
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int unsigned FrameLen   = 7;
  localparam int unsigned StoreDepth = FrameLen - 1;
  localparam int unsigned PosW       = 3;
  localparam int unsigned RunW       = 3;

  localparam logic [7:0]      SyncByte = 8'hff;
  localparam logic [PosW-1:0] LastPos  = PosW'(FrameLen - 1);
  localparam logic [RunW-1:0] LockRun  = RunW'(FrameLen - 1);

  // configuration register indexes
  localparam int unsigned     CfgIdxW         = 2;
  localparam logic [CfgIdxW-1:0] CfgWatchStation = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWatchSensor  = 2'd1;

  typedef enum logic [1:0] {
    KIND_SWEEP = 2'd0,
    KIND_AUX   = 2'd1,
    KIND_SYNC  = 2'd2,
    KIND_ERROR = 2'd3
  } frame_kind_e;

  // one decoded frame handed from the deframer to the rest of the block
  typedef struct packed {
    logic        valid;
    frame_kind_e kind;
    logic [3:0]  station;
    logic [1:0]  sensor;
    logic        sweep;
    logic [7:0]  rotation;
    logic [31:0] angle;
  } sfd_result_t;

endpackage

`default_nettype wire

/* hdl/sweep_frame_deframer_unit.sv */
// top level of the sweep frame deframer
//
// in channel: one received byte per request on rx_byte_i, valid/ready.
// out channel: one request per completed 7-byte frame carrying kind, the
// unpacked sweep fields (zero unless a sweep frame) and the two watched
// angles as they stand after that frame. bytes that complete no frame
// give no output request.
// cfg channel: cfg_index_i selects watch_station (0) or watch_sensor (1),
// always ready; write only while the block is idle.
// path: an accepted byte waits in the input register until the decode pass
// fires, which writes its result into the output register to be offered.
// throughput: one byte per cycle while no result waits, set by the single
// decode pass between the input register and the output register.
// stall: while a result waits, the decode pass halts and the input
// register holds one byte; in_ready_o falls once both are full.
// reset: hunting for lock, watch registers and watched angles zero, both
// channels empty.
`timescale 1ns / 1ps
`default_nettype none

module sweep_frame_deframer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       frame_kind_o,
  output logic [3:0]                       station_o,
  output logic [1:0]                       sensor_index_o,
  output logic                             sweep_index_o,
  output logic [7:0]                       rotation_count_o,
  output logic [31:0]                      angle_bits_o,
  output logic [31:0]                      watched_first_o,
  output logic [31:0]                      watched_second_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [sfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i
);
  import sfd_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        fire;
  sfd_result_t result;
  logic [31:0] watched_first, watched_second;
  logic [1:0]  kind_q;
  logic [3:0]  station_q;
  logic [1:0]  sensor_q;
  logic        sweep_q;
  logic [7:0]  rotation_q;
  logic [31:0] angle_q, wfirst_q, wsecond_q;

  assign cfg_ready_o = 1'b1;

  // handshake between input register and output register
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && result.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input byte register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  sfd_deframer u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (byte_q),
    .result_o (result)
  );

  sfd_watch u_watch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_i         (result),
    .watched_first_o  (watched_first),
    .watched_second_o (watched_second)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (fire && result.valid) begin
      kind_q     <= result.kind;
      station_q  <= result.station;
      sensor_q   <= result.sensor;
      sweep_q    <= result.sweep;
      rotation_q <= result.rotation;
      angle_q    <= result.angle;
      wfirst_q   <= watched_first;
      wsecond_q  <= watched_second;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_kind_o     = kind_q;
  assign station_o        = station_q;
  assign sensor_index_o   = sensor_q;
  assign sweep_index_o    = sweep_q;
  assign rotation_count_o = rotation_q;
  assign angle_bits_o     = angle_q;
  assign watched_first_o  = wfirst_q;
  assign watched_second_o = wsecond_q;

endmodule

`default_nettype wire

/* hdl/sfd_deframer.sv */
// byte hunting, frame gathering and frame check
`timescale 1ns / 1ps
`default_nettype none

module sfd_deframer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [7:0]          byte_i,
  output sfd_pkg::sfd_result_t     result_o
);
  import sfd_pkg::*;
  `include "assert_macros.svh"

  logic            locked_q, locked_d;
  logic [RunW-1:0] ff_run_q, ff_run_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            all_ff_q, all_ff_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      store_q [StoreDepth];
  logic            is_ff;
  logic            store_we;

  assign is_ff    = (byte_i == SyncByte);
  assign store_we = fire_i && locked_q && (pos_q != LastPos);

  // next state and frame decode
  always_comb begin
    locked_d = locked_q;
    ff_run_d = ff_run_q;
    pos_d    = pos_q;
    all_ff_d = all_ff_q;
    xor_d    = xor_q;
    result_o = '0;
    if (fire_i) begin
      if (!locked_q) begin
        if (is_ff) begin
          if (ff_run_q == LockRun) begin
            locked_d = 1'b1;
            ff_run_d = '0;
            pos_d    = '0;
            all_ff_d = 1'b1;
            xor_d    = '0;
          end else begin
            ff_run_d = ff_run_q + 1'b1;
          end
        end else begin
          ff_run_d = '0;
        end
      end else if (pos_q != LastPos) begin
        xor_d = xor_q ^ byte_i;
        if (!is_ff) begin
          all_ff_d = 1'b0;
        end
        pos_d = pos_q + 1'b1;
      end else begin
        result_o.valid = 1'b1;
        if (all_ff_q && is_ff) begin
          result_o.kind = KIND_SYNC;
        end else if (xor_q != byte_i) begin
          result_o.kind = KIND_ERROR;
          locked_d      = 1'b0;
          ff_run_d      = '0;
        end else if (store_q[0][7]) begin
          result_o.kind = KIND_AUX;
        end else begin
          result_o.kind     = KIND_SWEEP;
          result_o.station  = store_q[0][3:0];
          result_o.sensor   = store_q[0][5:4];
          result_o.sweep    = store_q[0][6];
          result_o.rotation = store_q[1];
          result_o.angle    = {store_q[5], store_q[4], store_q[3], store_q[2]};
        end
        pos_d    = '0;
        all_ff_d = 1'b1;
        xor_d    = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      ff_run_q <= '0;
      pos_q    <= '0;
      all_ff_q <= 1'b1;
      xor_q    <= '0;
    end else begin
      locked_q <= locked_d;
      ff_run_q <= ff_run_d;
      pos_q    <= pos_d;
      all_ff_q <= all_ff_d;
      xor_q    <= xor_d;
    end
  end

  // frame byte store, written at the current byte position
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[pos_q] <= byte_i;
    end
  end

  `SFD_ASSERT(a_run_idle_when_locked, locked_q |-> (ff_run_q == '0), "ff run counting while locked")
  `SFD_ASSERT(a_result_only_locked, result_o.valid |-> locked_q, "frame result while hunting")
  `SFD_ASSERT_NEXT(a_error_drops_lock, result_o.valid && (result_o.kind == KIND_ERROR), !locked_q, "lock kept after check error")
  `SFD_ASSERT(a_pos_in_frame, pos_q <= LastPos, "byte position past frame end")

endmodule

`default_nettype wire

/* hdl/sfd_watch.sv */
// watch registers and capture of watched sweep angles
`timescale 1ns / 1ps
`default_nettype none

module sfd_watch (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i,
  input  wire sfd_pkg::sfd_result_t         result_i,
  output logic [31:0]                       watched_first_o,
  output logic [31:0]                       watched_second_o
);
  import sfd_pkg::*;

  logic [7:0]  watch_station_q;
  logic [7:0]  watch_sensor_q;
  logic [31:0] first_q, first_d;
  logic [31:0] second_q, second_d;
  logic        hit;

  // match on the watched station and sensor, zero extended
  assign hit = result_i.valid && (result_i.kind == KIND_SWEEP)
            && ({4'b0, result_i.station} == watch_station_q)
            && ({6'b0, result_i.sensor} == watch_sensor_q);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (hit) begin
      if (result_i.sweep) begin
        second_d = result_i.angle;
      end else begin
        first_d = result_i.angle;
      end
    end
  end

  // values after this frame go out with its result
  assign watched_first_o  = first_d;
  assign watched_second_o = second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_station_q <= '0;
      watch_sensor_q  <= '0;
      first_q         <= '0;
      second_q        <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgWatchStation: watch_station_q <= cfg_data_i;
          CfgWatchSensor:  watch_sensor_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_sweep_frame_deframer_unit.sv */
// self-checking testbench of the sweep frame deframer with its own frame predictor
`timescale 1ns / 1ps

module tb_sweep_frame_deframer_unit;
  import sfd_pkg::*;

  // one completed frame as seen on the output channel
  typedef struct packed {
    frame_kind_e kind;
    logic [3:0]  station;
    logic [1:0]  sensor;
    logic        sweep;
    logic [7:0]  rotation;
    logic [31:0] angle;
    logic [31:0] first;
    logic [31:0] second;
  } frame_t;

  // one byte of the opening sequence, with an optional hand-typed frame
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    frame_t     want;
  } stim_row_t;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASE_BYTES    = 300;

  localparam frame_t NO_FRAME   = '0;
  localparam frame_t SYNC_FRESH = '{KIND_SYNC, 4'h0, 2'h0, 1'b0, 8'h00, 32'h0, 32'h0, 32'h0};
  localparam frame_t AUX_FRESH  = '{KIND_AUX, 4'h0, 2'h0, 1'b0, 8'h00, 32'h0, 32'h0, 32'h0};
  // second angle still holds the all-ones sweep just before it
  localparam frame_t ERR_LATE   =
    '{KIND_ERROR, 4'h0, 2'h0, 1'b0, 8'h00, 32'h0, 32'h0, 32'hffff_ffff};

  // hunting, lock, sync, auxiliary, all-ones sweep, check error
  localparam int unsigned OPENING_LEN = 37;
  localparam stim_row_t OPENING [OPENING_LEN] = '{
    '{8'hff, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME},
    '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME},
    '{8'hff, 1'b0, NO_FRAME},
    '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME},
    '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME},
    '{8'hff, 1'b1, SYNC_FRESH},
    '{8'h80, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h80, 1'b1, AUX_FRESH},
    '{8'h7f, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME},
    '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME}, '{8'hff, 1'b0, NO_FRAME},
    '{8'h80, 1'b0, NO_FRAME},
    '{8'h80, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h01, 1'b1, ERR_LATE}
  };

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i      = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [1:0]          frame_kind_o;
  logic [3:0]          station_o;
  logic [1:0]          sensor_index_o;
  logic                sweep_index_o;
  logic [7:0]          rotation_count_o;
  logic [31:0]         angle_bits_o;
  logic [31:0]         watched_first_o;
  logic [31:0]         watched_second_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = CfgWatchStation;
  logic [7:0]          cfg_data_i     = 8'h00;

  // predictor state, as after reset
  logic [7:0]  cfg_station   = 8'h00;
  logic [7:0]  cfg_sensor    = 8'h00;
  bit          in_lock       = 1'b0;
  int unsigned hunt_run      = 0;
  int unsigned frame_pos     = 0;
  logic [7:0]  frame_bytes [FrameLen-1];
  bit          frame_all_ff  = 1'b1;
  logic [7:0]  frame_parity  = 8'h00;
  logic [31:0] seen_first    = 32'h0;
  logic [31:0] seen_second   = 32'h0;

  frame_t      frames_due [$];
  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned kinds_seen [4] = '{0, 0, 0, 0};
  int unsigned send_gap_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_cycles  = 0;

  sweep_frame_deframer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_kind_o     (frame_kind_o),
    .station_o        (station_o),
    .sensor_index_o   (sensor_index_o),
    .sweep_index_o    (sweep_index_o),
    .rotation_count_o (rotation_count_o),
    .angle_bits_o     (angle_bits_o),
    .watched_first_o  (watched_first_o),
    .watched_second_o (watched_second_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  // advance the deframer by one byte; returns 1 when a frame completes
  function automatic bit deframe_byte(input logic [7:0] b, output frame_t res);
    res = NO_FRAME;
    // hunting: count the run of sync bytes
    if (!in_lock) begin
      if (b == SyncByte) begin
        hunt_run++;
        if (hunt_run >= FrameLen) begin
          in_lock      = 1'b1;
          hunt_run     = 0;
          frame_pos    = 0;
          frame_all_ff = 1'b1;
          frame_parity = 8'h00;
        end
      end else begin
        hunt_run = 0;
      end
      return 1'b0;
    end
    // gather the first six bytes of a frame
    if (frame_pos < FrameLen - 1) begin
      frame_bytes[frame_pos] = b;
      frame_parity ^= b;
      if (b != SyncByte) frame_all_ff = 1'b0;
      frame_pos++;
      return 1'b0;
    end
    // check byte closes the frame
    if (frame_all_ff && b == SyncByte) begin
      res.kind = KIND_SYNC;
    end else if (frame_parity != b) begin
      res.kind = KIND_ERROR;
      in_lock  = 1'b0;
      hunt_run = 0;
    end else if (frame_bytes[0][7]) begin
      res.kind = KIND_AUX;
    end else begin
      res.kind     = KIND_SWEEP;
      res.station  = frame_bytes[0][3:0];
      res.sensor   = frame_bytes[0][5:4];
      res.sweep    = frame_bytes[0][6];
      res.rotation = frame_bytes[1];
      res.angle    = {frame_bytes[5], frame_bytes[4], frame_bytes[3], frame_bytes[2]};
      // watch registers compare at full width, so values above the field never match
      if ({4'h0, res.station} == cfg_station && {6'h00, res.sensor} == cfg_sensor) begin
        if (res.sweep) seen_second = res.angle;
        else seen_first = res.angle;
      end
    end
    frame_pos    = 0;
    frame_all_ff = 1'b1;
    frame_parity = 8'h00;
    res.first    = seen_first;
    res.second   = seen_second;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // send one byte, then predict what it completes
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_t want = NO_FRAME);
    frame_t res;
    bit     done;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    done = deframe_byte(b, res);
    if (typed) frames_due.push_back(want);
    else if (done) frames_due.push_back(res);
  endtask

  // register write request; the caller lowers valid after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgWatchStation) cfg_station = val;
    else cfg_sensor = val;
  endtask

  task automatic set_watch(input logic [7:0] station, input logic [7:0] sensor);
    write_reg(CfgWatchStation, station);
    write_reg(CfgWatchSensor, sensor);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every frame, then let bytes with no result clear the pipe
  task automatic drain();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed frames, with noise while hunting and some broken frames
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  fr [FrameLen];
    logic [7:0]  parity;
    sent = 0;
    while (sent < n_bytes) begin
      if (!in_lock) begin
        push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : SyncByte);
        sent++;
      end else if (frame_pos != 0) begin
        push_byte(8'($urandom));
        sent++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          foreach (fr[k]) fr[k] = SyncByte;
        end else begin
          fr[0] = 8'($urandom);
          if (pick < 60) begin
            // sweep header, half of them aimed at the watched pair
            fr[0][7] = 1'b0;
            if ($urandom_range(0, 1)) begin
              fr[0][3:0] = cfg_station[3:0];
              fr[0][5:4] = cfg_sensor[1:0];
            end
          end else if (pick < 75) begin
            fr[0][7] = 1'b1;
          end
          parity = fr[0];
          for (int k = 1; k < FrameLen - 1; k++) begin
            fr[k] = edgy_byte();
            parity ^= fr[k];
          end
          if (pick < 75) fr[FrameLen-1] = parity;
          else if (pick < 90) fr[FrameLen-1] = parity ^ 8'($urandom_range(1, 255));
          else fr[FrameLen-1] = 8'($urandom);
        end
        foreach (fr[k]) push_byte(fr[k]);
        sent += FrameLen;
      end
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each delivered frame with the oldest prediction
  always @(posedge clk_i) begin
    frame_t got;
    frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{frame_kind_e'(frame_kind_o), station_o, sensor_index_o, sweep_index_o,
              rotation_count_o, angle_bits_o, watched_first_o, watched_second_o};
      kinds_seen[got.kind]++;
      if (frames_due.size() == 0) begin
        $error("frame of kind %0d with none expected", got.kind);
        fail_count++;
      end else begin
        want = frames_due.pop_front();
        check_field("frame_kind", 32'(want.kind), 32'(got.kind));
        check_field("station", 32'(want.station), 32'(got.station));
        check_field("sensor_index", 32'(want.sensor), 32'(got.sensor));
        check_field("sweep_index", 32'(want.sweep), 32'(got.sweep));
        check_field("rotation_count", 32'(want.rotation), 32'(got.rotation));
        check_field("angle_bits", want.angle, got.angle);
        check_field("watched_first", want.first, got.first);
        check_field("watched_second", want.second, got.second);
      end
    end
  end

  // watchdog on any request moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening sequence, watching the top station and sensor
    send_gap_pct   = 30;
    recv_stall_pct = 76;
    set_watch(8'd15, 8'd3);
    for (int i = 0; i < OPENING_LEN; i++) begin
      push_byte(OPENING[i].b, OPENING[i].typed, OPENING[i].want);
    end
    drain();

    // random phases: watch setting changes between them, idling pattern in all but the last
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 30;
          recv_stall_pct = 76;
          set_watch(8'd0, 8'd0);
        end
        1: begin
          send_gap_pct   = 76;
          recv_stall_pct = 30;
          set_watch(8'd255, 8'd255);
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          set_watch(8'($urandom_range(0, 15)), 8'($urandom_range(0, 3)));
        end
        default: begin
          set_watch(8'($urandom), 8'($urandom));
        end
      endcase
      random_traffic(PHASE_BYTES);
      drain();
    end

    if (frames_due.size() != 0) begin
      $error("%0d predicted frames never delivered", frames_due.size());
      fail_count++;
    end
    $display("sent %0d bytes across hunting, lock and five watch settings", bytes_sent);
    $display("frames: %0d sweep, %0d auxiliary, %0d sync, %0d check error; %0d mismatches",
             kinds_seen[KIND_SWEEP], kinds_seen[KIND_AUX], kinds_seen[KIND_SYNC],
             kinds_seen[KIND_ERROR], fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/sfd_pkg.sv
hdl/sfd_deframer.sv
hdl/sfd_watch.sv
hdl/sweep_frame_deframer_unit.sv
tb/tb_sweep_frame_deframer_unit.sv
